@@ src/mi3_pkg.sv @@
// mi3_pkg: types and constants shared by the 3x3 adjugate inverse block
// no dependencies
package mi3_pkg;

    localparam int unsigned ENTRY_W   = 32;
    localparam int unsigned TOL_W     = 48;
    localparam int unsigned CMAG_W    = 64;
    localparam int unsigned DMAG_W    = 97;
    localparam int unsigned DIV_STEPS = 32;
    localparam logic [TOL_W-1:0] TOL_RESET = 48'd4295;

    typedef struct packed {
        logic signed [ENTRY_W-1:0] m00;
        logic signed [ENTRY_W-1:0] m01;
        logic signed [ENTRY_W-1:0] m02;
        logic signed [ENTRY_W-1:0] m10;
        logic signed [ENTRY_W-1:0] m11;
        logic signed [ENTRY_W-1:0] m12;
        logic signed [ENTRY_W-1:0] m20;
        logic signed [ENTRY_W-1:0] m21;
        logic signed [ENTRY_W-1:0] m22;
    } t_in;

    typedef struct packed {
        logic signed [ENTRY_W-1:0] r00;
        logic signed [ENTRY_W-1:0] r01;
        logic signed [ENTRY_W-1:0] r02;
        logic signed [ENTRY_W-1:0] r10;
        logic signed [ENTRY_W-1:0] r11;
        logic signed [ENTRY_W-1:0] r12;
        logic signed [ENTRY_W-1:0] r20;
        logic signed [ENTRY_W-1:0] r21;
        logic signed [ENTRY_W-1:0] r22;
        logic                      ok;
        logic                      saturated;
    } t_out;

    // classified request handed from front to back
    typedef struct packed {
        logic [8:0][CMAG_W-1:0] mag;
        logic [8:0]             neg;
        logic [DMAG_W-1:0]      dmag;
        logic                   dneg;
        logic                   ok;
    } t_mid;

endpackage

@@ src/mi3_front.sv @@
// mi3_front: cofactors, determinant and singular test, eight register stages
// depends on mi3_pkg
module mi3_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_push,
    input  mi3_pkg::t_in                  i_item,
    input  logic [mi3_pkg::TOL_W-1:0]     i_tol,
    output logic                          o_mid_push,
    output mi3_pkg::t_mid                 o_mid
);

    localparam int PA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int PB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int PC [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int PD [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    logic signed [31:0] w_m [9];
    assign w_m[0] = i_item.m00;
    assign w_m[1] = i_item.m01;
    assign w_m[2] = i_item.m02;
    assign w_m[3] = i_item.m10;
    assign w_m[4] = i_item.m11;
    assign w_m[5] = i_item.m12;
    assign w_m[6] = i_item.m20;
    assign w_m[7] = i_item.m21;
    assign w_m[8] = i_item.m22;

    logic [8:1] r_v;

    logic signed [63:0] r1_pa [9];
    logic signed [63:0] r1_pb [9];
    logic signed [31:0] r1_e  [3];
    logic signed [64:0] r2_c  [9];
    logic signed [31:0] r2_e  [3];
    logic [31:0]        r3_emag [3];
    logic [2:0]         r3_eneg;
    logic [63:0]        r4_pl [3];
    logic [63:0]        r4_ph [3];
    logic [2:0]         r4_tneg;
    logic signed [97:0] r5_t [3];
    logic signed [97:0] r6_det;
    logic [96:0]        r7_dmag;
    logic               r7_dneg;
    logic [96:0]        r8_dmag;
    logic               r8_dneg;
    logic               r8_ok;

    // cofactor magnitudes and signs travel alongside from stage 3
    logic [8:0][63:0]   r_cmag [3:8];
    logic [8:0]         r_cneg [3:8];

    logic [95:0] w_t [3];
    logic [97:0] w_tx [3];
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_t[j]  = {r4_ph[j], 32'd0} + {32'd0, r4_pl[j]};
            w_tx[j] = {2'b00, w_t[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[7:1], i_push};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r1_pa[k] <= 64'(w_m[PA[k]]) * 64'(w_m[PB[k]]);
                r1_pb[k] <= 64'(w_m[PC[k]]) * 64'(w_m[PD[k]]);
                r2_c[k]  <= {r1_pa[k][63], r1_pa[k]} - {r1_pb[k][63], r1_pb[k]};
                r_cmag[3][k] <= r2_c[k][64] ? 64'(-r2_c[k]) : r2_c[k][63:0];
                r_cneg[3][k] <= r2_c[k][64];
            end
            for (int j = 0; j < 3; j++) begin
                r1_e[j]    <= w_m[j];
                r2_e[j]    <= r1_e[j];
                r3_emag[j] <= r2_e[j][31] ? (~r2_e[j] + 32'd1) : r2_e[j];
                r3_eneg[j] <= r2_e[j][31];
                r4_pl[j]   <= {32'd0, r3_emag[j]} * {32'd0, r_cmag[3][3*j][31:0]};
                r4_ph[j]   <= {32'd0, r3_emag[j]} * {32'd0, r_cmag[3][3*j][63:32]};
                r4_tneg[j] <= r3_eneg[j] ^ r_cneg[3][3*j];
                r5_t[j]    <= r4_tneg[j] ? $signed(~w_tx[j] + 98'd1) : $signed(w_tx[j]);
            end
            for (int s = 4; s <= 8; s++) begin
                r_cmag[s] <= r_cmag[s-1];
                r_cneg[s] <= r_cneg[s-1];
            end
            r6_det  <= r5_t[0] + r5_t[1] + r5_t[2];
            r7_dmag <= r6_det[97] ? 97'(-r6_det) : r6_det[96:0];
            r7_dneg <= r6_det[97];
            r8_dmag <= r7_dmag;
            r8_dneg <= r7_dneg;
            r8_ok   <= r7_dmag > {33'd0, i_tol, 16'd0};
        end
    end

    assign o_mid_push = i_en && r_v[8];
    assign o_mid.mag  = r_cmag[8];
    assign o_mid.neg  = r_cneg[8];
    assign o_mid.dmag = r8_dmag;
    assign o_mid.dneg = r8_dneg;
    assign o_mid.ok   = r8_ok;

endmodule

@@ src/mi3_midq.sv @@
// mi3_midq: two-entry request queue between front and back
// depends on mi3_pkg
module mi3_midq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mi3_pkg::t_mid i_data,
    input  logic          i_pop,
    output mi3_pkg::t_mid o_data,
    output logic          o_valid,
    output logic [1:0]    o_cnt
);

    mi3_pkg::t_mid r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_data  = r_mem[r_rp];
    assign o_valid = (r_cnt != 2'd0);
    assign o_cnt   = r_cnt;

endmodule

@@ src/mi3_back.sv @@
// mi3_back: 32-step pipelined restoring divider over nine lanes, clipping
// and a two-entry result queue; depends on mi3_pkg
module mi3_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mi3_pkg::t_mid i_mid,
    input  logic          i_mid_valid,
    output logic          o_mid_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output mi3_pkg::t_out o_result
);

    localparam int NS = mi3_pkg::DIV_STEPS;

    logic [NS:0]      r_v;
    logic [8:0][96:0] r_rem  [NS+1];
    logic [8:0][31:0] r_q    [NS+1];
    logic [8:0]       r_over [NS+1];
    logic [8:0]       r_neg  [NS+1];
    logic             r_ok   [NS+1];
    logic [96:0]      r_dmag [NS+1];

    logic [8:0][96:0] n_rem [NS+1];
    logic [8:0][31:0] n_q   [NS+1];

    mi3_pkg::t_out r_omem [2];
    logic          r_owp;
    logic          r_orp;
    logic [1:0]    r_ocnt;

    logic w_opop, w_en, w_opush;
    assign w_opop    = i_pop && (r_ocnt != 2'd0);
    assign w_en      = (r_ocnt != 2'd2) || w_opop;
    assign w_opush   = w_en && r_v[NS];
    assign o_mid_pop = w_en && i_mid_valid;

    // one quotient bit per stage when ok; remainder stays below the divisor only if it starts below
    logic [97:0] w_sh;
    always_comb begin
        w_sh = '0;
        n_rem[0] = '0;
        n_q[0]   = '0;
        for (int s = 1; s <= NS; s++) begin
            for (int k = 0; k < 9; k++) begin
                w_sh = {r_rem[s-1][k], 1'b0};
                n_rem[s][k] = r_rem[s-1][k];
                n_q[s][k]   = r_q[s-1][k];
                if (r_ok[s-1]) begin
                    if (w_sh >= {1'b0, r_dmag[s-1]}) begin
                        n_rem[s][k] = 97'(w_sh - {1'b0, r_dmag[s-1]});
                        n_q[s][k]   = {r_q[s-1][k][30:0], 1'b1};
                    end else begin
                        n_rem[s][k] = w_sh[96:0];
                        n_q[s][k]   = {r_q[s-1][k][30:0], 1'b0};
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NS-1:0], i_mid_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 9; k++) begin
                r_rem[0][k]  <= {33'd0, i_mid.mag[k]};
                r_q[0][k]    <= '0;
                r_over[0][k] <= {33'd0, i_mid.mag[k]} >= i_mid.dmag;
                r_neg[0][k]  <= i_mid.neg[k] ^ (i_mid.ok && i_mid.dneg);
            end
            r_ok[0]   <= i_mid.ok;
            r_dmag[0] <= i_mid.dmag;
            for (int s = 1; s <= NS; s++) begin
                r_rem[s]  <= n_rem[s];
                r_q[s]    <= n_q[s];
                r_over[s] <= r_over[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_ok[s]   <= r_ok[s-1];
                r_dmag[s] <= r_dmag[s-1];
            end
        end
    end

    function automatic logic [32:0] f_clip(input logic neg, input logic big,
                                           input logic [47:0] val);
        logic [47:0] lim;
        logic [31:0] v;
        logic        sat;
        lim = neg ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;
        if (big || (val > lim)) begin
            sat = 1'b1;
            v   = lim[31:0];
        end else begin
            sat = 1'b0;
            v   = val[31:0];
        end
        return {sat, neg ? (~v + 32'd1) : v};
    endfunction

    logic [32:0]      w_clip [9];
    logic [8:0][31:0] w_r;
    logic             w_sat;
    always_comb begin
        w_sat = 1'b0;
        for (int k = 0; k < 9; k++) begin
            if (r_ok[NS]) begin
                w_clip[k] = f_clip(r_neg[NS][k], r_over[NS][k], {16'd0, r_q[NS][k]});
            end else begin
                w_clip[k] = f_clip(r_neg[NS][k], 1'b0, r_rem[NS][k][63:16]);
            end
            w_r[k] = w_clip[k][31:0];
            w_sat  = w_sat | w_clip[k][32];
        end
    end

    mi3_pkg::t_out w_res;
    always_comb begin
        w_res.r00       = w_r[0];
        w_res.r01       = w_r[1];
        w_res.r02       = w_r[2];
        w_res.r10       = w_r[3];
        w_res.r11       = w_r[4];
        w_res.r12       = w_r[5];
        w_res.r20       = w_r[6];
        w_res.r21       = w_r[7];
        w_res.r22       = w_r[8];
        w_res.ok        = r_ok[NS];
        w_res.saturated = w_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (w_opush) r_owp <= ~r_owp;
            if (w_opop)  r_orp <= ~r_orp;
            r_ocnt <= r_ocnt + 2'(w_opush) - 2'(w_opop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_opush) r_omem[r_owp] <= w_res;
    end

    assign o_empty  = (r_ocnt == 2'd0);
    assign o_result = r_omem[r_orp];

    a_ocnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt != 2'd3) else $error("result queue count out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_opush |-> (r_ocnt != 2'd2 || w_opop)) else $error("result queue overflow");
    a_mid_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mid_pop |-> i_mid_valid) else $error("request taken from empty queue");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_v)) else $error("divider moved while stalled");

endmodule

@@ src/matrix3_inverse_adjugate.sv @@
// matrix3_inverse_adjugate: top level, tolerance register, front, queue, back
// depends on mi3_pkg, mi3_front, mi3_midq, mi3_back
//
// One 3x3 Q16.16 matrix is pushed per cycle while full is low, and one result
// leaves per cycle while pop is held and empty is low; sustained rate is one
// matrix per clock while pop is held. A request enters the first of eight
// stages of cofactor, determinant and tolerance logic at its accepting edge,
// then passes seven more front stages, the request queue, 33 stages of the
// bit-per-stage divider with its 32 quotient steps, and the write into the
// result queue, after which empty goes low. Singular matrices (|det| at or
// below the tolerance, Q16.32) return the truncated adjugate with ok low. The
// tolerance may be written only while the block holds no request.
module matrix3_inverse_adjugate (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  mi3_pkg::t_in              i_item,
    output logic                      empty,
    input  logic                      pop,
    output mi3_pkg::t_out             o_result,
    input  logic                      i_cfg_we,
    input  logic [mi3_pkg::TOL_W-1:0] i_cfg_data
);

    logic [mi3_pkg::TOL_W-1:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= mi3_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_data;
        end
    end

    logic          w_en_f;
    logic          w_mid_push;
    mi3_pkg::t_mid w_mid_in;
    mi3_pkg::t_mid w_mid_out;
    logic          w_mid_valid;
    logic [1:0]    w_mid_cnt;
    logic          w_mid_pop;

    assign w_en_f = (w_mid_cnt != 2'd2) || w_mid_pop;
    assign full   = ~w_en_f;

    mi3_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en_f),
        .i_push     (push),
        .i_item     (i_item),
        .i_tol      (r_tol),
        .o_mid_push (w_mid_push),
        .o_mid      (w_mid_in)
    );

    mi3_midq u_midq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_mid_in),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_out),
        .o_valid (w_mid_valid),
        .o_cnt   (w_mid_cnt)
    );

    mi3_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid       (w_mid_out),
        .i_mid_valid (w_mid_valid),
        .o_mid_pop   (w_mid_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

@@ tb/sv/mi3_checker.sv @@
`timescale 1ns / 100ps
// mi3_checker: watches the request and result channels of the 3x3 inverse,
// predicts each result and compares it field by field; depends on mi3_pkg
module mi3_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic                      i_full,
    input  mi3_pkg::t_in              i_item,
    input  logic                      i_empty,
    input  logic                      i_pop,
    input  mi3_pkg::t_out             i_result,
    input  logic                      i_cfg_we,
    input  logic [mi3_pkg::TOL_W-1:0] i_cfg_data,
    output int                        o_errors,
    output int                        o_pending
);

    mi3_pkg::t_out             inv_q[$];
    logic [mi3_pkg::TOL_W-1:0] tol_copy;
    string            fld_name [9] = '{"r00", "r01", "r02", "r10", "r11", "r12",
                                       "r20", "r21", "r22"};

    function automatic mi3_pkg::t_out predict_inverse(input mi3_pkg::t_in m,
                                                      input logic [mi3_pkg::TOL_W-1:0] tol);
        logic signed [127:0] e [9];
        logic signed [127:0] c [9];
        logic signed [127:0] det;
        logic [127:0]        dmag, tl, mag, v, lim;
        logic [31:0]         r [9];
        logic                neg, ok, sat;
        mi3_pkg::t_out       o;
        e[0] = m.m00; e[1] = m.m01; e[2] = m.m02;
        e[3] = m.m10; e[4] = m.m11; e[5] = m.m12;
        e[6] = m.m20; e[7] = m.m21; e[8] = m.m22;
        c[0] = e[4] * e[8] - e[5] * e[7];
        c[1] = e[2] * e[7] - e[1] * e[8];
        c[2] = e[1] * e[5] - e[2] * e[4];
        c[3] = e[5] * e[6] - e[3] * e[8];
        c[4] = e[0] * e[8] - e[2] * e[6];
        c[5] = e[2] * e[3] - e[0] * e[5];
        c[6] = e[3] * e[7] - e[4] * e[6];
        c[7] = e[1] * e[6] - e[0] * e[7];
        c[8] = e[0] * e[4] - e[1] * e[3];
        det  = e[0] * c[0] + e[1] * c[3] + e[2] * c[6];
        dmag = det[127] ? -det : det;
        tl   = 128'(tol) << 16;
        ok   = dmag > tl;
        sat  = 1'b0;
        for (int k = 0; k < 9; k++) begin
            mag = c[k][127] ? -c[k] : c[k];
            neg = c[k][127];
            if (ok) begin
                // exact quotient of Q32.32 by Q48.48, truncated toward zero
                v   = (mag << 32) / dmag;
                neg = neg ^ det[127];
            end else begin
                v = mag >> 16;
            end
            lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
            if (v > lim) begin
                sat = 1'b1;
                v   = lim;
            end
            r[k] = neg ? 32'(-v) : 32'(v);
        end
        o.r00 = r[0]; o.r01 = r[1]; o.r02 = r[2];
        o.r10 = r[3]; o.r11 = r[4]; o.r12 = r[5];
        o.r20 = r[6]; o.r21 = r[7]; o.r22 = r[8];
        o.ok        = ok;
        o.saturated = sat;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
        tol_copy  = mi3_pkg::TOL_RESET;
    end

    always @(posedge i_clk) begin
        mi3_pkg::t_out want;
        if (!i_rst_n) begin
            tol_copy = mi3_pkg::TOL_RESET;
        end else begin
            if (i_cfg_we) begin
                tol_copy = i_cfg_data;
            end
            if (i_push && !i_full) begin
                inv_q.push_back(predict_inverse(i_item, tol_copy));
            end
            if (i_pop && !i_empty) begin
                if (inv_q.size() == 0) begin
                    report_mismatch("unexpected result", 32'(i_result[289:258]), 32'd0);
                end else begin
                    want = inv_q.pop_front();
                    for (int k = 0; k < 9; k++) begin
                        if (i_result[289-32*k -: 32] !== want[289-32*k -: 32]) begin
                            report_mismatch(fld_name[k], i_result[289-32*k -: 32],
                                            want[289-32*k -: 32]);
                        end
                    end
                    if (i_result.ok !== want.ok) begin
                        report_mismatch("ok", 32'(i_result.ok), 32'(want.ok));
                    end
                    if (i_result.saturated !== want.saturated) begin
                        report_mismatch("saturated", 32'(i_result.saturated),
                                        32'(want.saturated));
                    end
                end
            end
        end
        o_pending = inv_q.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for matrix3_inverse_adjugate
// depends on mi3_pkg, matrix3_inverse_adjugate and mi3_checker
module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                      clk;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    mi3_pkg::t_in              item;
    logic                      empty;
    logic                      pop;
    mi3_pkg::t_out             result;
    logic                      cfg_we;
    logic [mi3_pkg::TOL_W-1:0] cfg_data;
    int               errors;
    int               pending;
    int               tx_idle;
    int               rx_idle;
    int               sent;
    int               quiet_cycles;

    matrix3_inverse_adjugate dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .push       (push),
        .full       (full),
        .i_item     (item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (result),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    mi3_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_push     (push),
        .i_full     (full),
        .i_item     (item),
        .i_empty    (empty),
        .i_pop      (pop),
        .i_result   (result),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] small_entry();
        // values within about +-4.0 keep the inverse meaningful
        return 32'($signed($urandom_range(524288)) - 262144);
    endfunction

    function automatic mi3_pkg::t_in random_matrix();
        mi3_pkg::t_in m;
        int    kind;
        logic [31:0] k;
        kind = $urandom_range(9);
        if (kind < 3) begin
            m = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom};
        end else begin
            m = {small_entry(), small_entry(), small_entry(), small_entry(),
                 small_entry(), small_entry(), small_entry(), small_entry(),
                 small_entry()};
            if (kind == 8) begin
                // third row a copy of the first, nudged: near singular
                k = 32'($urandom_range(8));
                m.m20 = m.m00 + k;
                m.m21 = m.m01;
                m.m22 = m.m02;
            end else if (kind == 9) begin
                // tiny diagonal makes a huge inverse
                m = '0;
                m.m00 = 32'($urandom_range(4096));
                m.m11 = 32'($urandom_range(4096));
                m.m22 = 32'($urandom_range(4096));
                if ($urandom_range(1)) m.m11 = -m.m11;
            end
        end
        return m;
    endfunction

    task automatic send_matrix(input mi3_pkg::t_in m);
        push <= 1'b1;
        item <= m;
        @(posedge clk);
        while (full) @(posedge clk);
        sent++;
        if ($urandom_range(99) < tx_idle) begin
            push <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    task automatic drain_and_write(input logic [mi3_pkg::TOL_W-1:0] value);
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(input int count, input int sender_idle, input int recv_idle);
        tx_idle = sender_idle;
        rx_idle = recv_idle;
        for (int i = 0; i < count; i++) begin
            send_matrix(random_matrix());
        end
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            pop <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty) || !rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", pending);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        mi3_pkg::t_in m;
        rst_n        = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        item         = '0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        tx_idle      = 0;
        rx_idle      = 0;
        sent         = 0;
        quiet_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed matrices under the reset tolerance
        send_matrix('0);
        m = '0; m.m00 = 32'h0001_0000; m.m11 = 32'h0001_0000; m.m22 = 32'h0001_0000;
        send_matrix(m);
        m.m11 = 32'hffff_0000;
        send_matrix(m);
        send_matrix({9{32'h7fff_ffff}});
        send_matrix({9{32'h8000_0000}});
        send_matrix({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                     32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                     32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
        m = '0; m.m00 = 32'h8000_0000; m.m11 = 32'h7fff_ffff; m.m22 = 32'h8000_0000;
        m.m01 = 32'h7fff_ffff; m.m12 = 32'h8000_0000; m.m20 = 32'h7fff_ffff;
        send_matrix(m);
        // tiny diagonal: within tolerance here, inverted once tolerance is zero
        m = '0; m.m00 = 32'h10; m.m11 = 32'h10; m.m22 = 32'h10;
        send_matrix(m);
        m = '0; m.m00 = 32'h100; m.m11 = 32'hffff_ff00; m.m22 = 32'h100;
        send_matrix(m);
        send_matrix({32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                     32'h0004_0000, 32'h0005_0000, 32'h0006_0000,
                     32'h0007_0000, 32'h0008_0000, 32'h000a_0000});
        send_matrix({32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                     32'h0002_0000, 32'h0004_0000, 32'h0006_0000,
                     32'h0007_0000, 32'h0008_0000, 32'h0009_0000});

        drain_and_write('0);
        m = '0; m.m00 = 32'h1; m.m11 = 32'h1; m.m22 = 32'hffff_ffff;
        send_matrix(m);
        m = '0; m.m00 = 32'h10; m.m11 = 32'h10; m.m22 = 32'h10;
        send_matrix(m);
        m = '0; m.m00 = 32'h8000_0000; m.m11 = 32'h8000_0000; m.m22 = 32'h8000_0000;
        send_matrix(m);
        random_phase(450, 31, 84);

        drain_and_write({mi3_pkg::TOL_W{1'b1}});
        random_phase(200, 84, 31);
        drain_and_write(48'(($urandom_range(65535) << 16) | $urandom));
        random_phase(250, 84, 31);

        drain_and_write(mi3_pkg::TOL_RESET);
        random_phase(220, 0, 0);
        // hold off until every outstanding result has come back
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        random_phase(230, 0, 0);

        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);

        $display("%0d matrices sent across four tolerance settings", sent);
        $display("with sender and receiver stalls swapped, then back to back");
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/mi3_pkg.sv
src/mi3_front.sv
src/mi3_midq.sv
src/mi3_back.sv
src/matrix3_inverse_adjugate.sv
tb/sv/mi3_checker.sv
tb/sv/tb_top.sv
